### src/super_eagle_2x_upscale_kernel_assert.svh
// Assertion macros used by the upscale kernel source.
`ifndef SUPER_EAGLE_2X_UPSCALE_KERNEL_ASSERT_SVH
`define SUPER_EAGLE_2X_UPSCALE_KERNEL_ASSERT_SVH

// Same-cycle implication, reset masked.
`define SE2X_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("se2x: same-cycle check failed");

// Next-cycle implication, reset masked.
`define SE2X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("se2x: next-cycle check failed");

`endif

### src/se2x_pkg.sv
package se2x_pkg;

	// pixel_format codes
	localparam logic FMT_RGB565   = 1'b0;
	localparam logic FMT_XRGB8888 = 1'b1;

	// channel masks, XRGB8888
	localparam logic [31:0] MASK_HALF_8888    = 32'hFEFE_FEFE;
	localparam logic [31:0] MASK_ONE_8888     = 32'h0101_0101;
	localparam logic [31:0] MASK_QUARTER_8888 = 32'hFCFC_FCFC;
	localparam logic [31:0] MASK_LOW2_8888    = 32'h0303_0303;
	localparam logic [31:0] MASK_ALL_8888     = 32'hFFFF_FFFF;

	// channel masks, RGB565 in the low half
	localparam logic [31:0] MASK_HALF_565    = 32'h0000_F7DE;
	localparam logic [31:0] MASK_ONE_565     = 32'h0000_0821;
	localparam logic [31:0] MASK_QUARTER_565 = 32'h0000_E79C;
	localparam logic [31:0] MASK_LOW2_565    = 32'h0000_1863;
	localparam logic [31:0] MASK_ALL_565     = 32'h0000_FFFF;

	typedef struct packed {
		logic [31:0] above_center;
		logic [31:0] above_right;
		logic [31:0] mid_left;
		logic [31:0] center_pixel;
		logic [31:0] mid_right;
		logic [31:0] mid_far_right;
		logic [31:0] below_left;
		logic [31:0] below_center;
		logic [31:0] below_right;
		logic [31:0] below_far_right;
		logic [31:0] second_below_center;
		logic [31:0] second_below_right;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_top_left;
		logic [31:0] out_top_right;
		logic [31:0] out_bottom_left;
		logic [31:0] out_bottom_right;
	} out_item_t;

	// drop bits 31..16 in RGB565 mode
	function automatic logic [31:0] fmt_mask(input logic [31:0] a, input logic fmt);
		return (fmt == FMT_XRGB8888) ? a : {16'h0000, a[15:0]};
	endfunction

	// 1:1 per-channel average, truncated; adds the carry only when both low bits are set
	function automatic logic [31:0] avg2(input logic [31:0] a, input logic [31:0] b,
			input logic fmt);
		logic [31:0] half;
		logic [31:0] one;
		logic [31:0] all;
		logic [31:0] r;
		half = (fmt == FMT_XRGB8888) ? MASK_HALF_8888 : MASK_HALF_565;
		one  = (fmt == FMT_XRGB8888) ? MASK_ONE_8888 : MASK_ONE_565;
		all  = (fmt == FMT_XRGB8888) ? MASK_ALL_8888 : MASK_ALL_565;
		r = ((a & half) >> 1) + ((b & half) >> 1) + (a & b & one);
		return r & all;
	endfunction

	// four-input per-channel average with carried low bits
	function automatic logic [31:0] avg4(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d, input logic fmt);
		logic [31:0] quarter;
		logic [31:0] low2;
		logic [31:0] all;
		logic [31:0] hi;
		logic [31:0] lo;
		quarter = (fmt == FMT_XRGB8888) ? MASK_QUARTER_8888 : MASK_QUARTER_565;
		low2    = (fmt == FMT_XRGB8888) ? MASK_LOW2_8888 : MASK_LOW2_565;
		all     = (fmt == FMT_XRGB8888) ? MASK_ALL_8888 : MASK_ALL_565;
		hi = ((a & quarter) >> 2) + ((b & quarter) >> 2)
			+ ((c & quarter) >> 2) + ((d & quarter) >> 2);
		lo = (((a & low2) + (b & low2) + (c & low2) + (d & low2)) >> 2) & low2;
		return (hi + lo) & all;
	endfunction

	// one vote term: 1 when a differs from either of c, d
	function automatic logic differs(input logic [31:0] a, input logic [31:0] c,
			input logic [31:0] d);
		return (a != c) || (a != d);
	endfunction

endpackage

### src/se2x_core.sv
module se2x_core (
	input  se2x_pkg::in_item_t  item,
	input  logic                fmt,
	output se2x_pkg::out_item_t result
);
	import se2x_pkg::*;

	logic [31:0] b1, b2, c4, c5, c6, s2, c1, c2, c3, s1, a1, a2;
	logic        diag_26, diag_53;
	logic [2:0]  votes_6, votes_5;
	logic [31:0] avg_56, avg_23, d1, d2;
	logic [31:0] tl, tr, bl, br;

	// neighbourhood with format masking applied
	assign b1 = fmt_mask(item.above_center, fmt);
	assign b2 = fmt_mask(item.above_right, fmt);
	assign c4 = fmt_mask(item.mid_left, fmt);
	assign c5 = fmt_mask(item.center_pixel, fmt);
	assign c6 = fmt_mask(item.mid_right, fmt);
	assign s2 = fmt_mask(item.mid_far_right, fmt);
	assign c1 = fmt_mask(item.below_left, fmt);
	assign c2 = fmt_mask(item.below_center, fmt);
	assign c3 = fmt_mask(item.below_right, fmt);
	assign s1 = fmt_mask(item.below_far_right, fmt);
	assign a1 = fmt_mask(item.second_below_center, fmt);
	assign a2 = fmt_mask(item.second_below_right, fmt);

	// diagonal compares
	assign diag_26 = (c2 == c6);
	assign diag_53 = (c5 == c3);

	// vote over outer neighbours: sign of (votes_6 - votes_5)
	assign votes_6 = 3'(differs(c6, c1, a1)) + 3'(differs(c6, c4, b1))
		+ 3'(differs(c6, a2, s1)) + 3'(differs(c6, b2, s2));
	assign votes_5 = 3'(differs(c5, c1, a1)) + 3'(differs(c5, c4, b1))
		+ 3'(differs(c5, a2, s1)) + 3'(differs(c5, b2, s2));

	// shared blends
	assign avg_56 = avg2(c5, c6, fmt);
	assign avg_23 = avg2(c2, c3, fmt);
	assign d1     = avg2(c2, c6, fmt);
	assign d2     = avg2(c5, c3, fmt);

	// case select and output blends
	always_comb begin
		tl = c5;
		tr = c2;
		bl = c2;
		br = c5;
		if (diag_26 && !diag_53) begin
			tr = c2;
			bl = c2;
			if (c1 == c2 || c6 == b2) begin
				tl = avg2(c2, avg2(c2, c5, fmt), fmt);
			end else begin
				tl = avg_56;
			end
			if (c6 == s2 || c2 == a1) begin
				br = avg2(c2, avg2(c2, c3, fmt), fmt);
			end else begin
				br = avg_23;
			end
		end else if (diag_53 && !diag_26) begin
			tl = c5;
			br = c5;
			if (b1 == c5 || c3 == s1) begin
				tr = avg2(c5, avg2(c5, c6, fmt), fmt);
			end else begin
				tr = avg_56;
			end
			if (c3 == a2 || c4 == c5) begin
				bl = avg2(c5, avg2(c5, c2, fmt), fmt);
			end else begin
				bl = avg_23;
			end
		end else if (diag_53 && diag_26) begin
			if (votes_6 > votes_5) begin
				tr = c2;
				bl = c2;
				tl = avg_56;
				br = avg_56;
			end else if (votes_6 < votes_5) begin
				tl = c5;
				br = c5;
				tr = avg_56;
				bl = avg_56;
			end else begin
				tl = c5;
				br = c5;
				tr = c2;
				bl = c2;
			end
		end else begin
			br = avg4(c3, c3, c3, d1, fmt);
			tl = avg4(c5, c5, c5, d1, fmt);
			bl = avg4(c2, c2, c2, d2, fmt);
			tr = avg4(c6, c6, c6, d2, fmt);
		end
	end

	assign result.out_top_left     = fmt_mask(tl, fmt);
	assign result.out_top_right    = fmt_mask(tr, fmt);
	assign result.out_bottom_left  = fmt_mask(bl, fmt);
	assign result.out_bottom_right = fmt_mask(br, fmt);

endmodule

### src/super_eagle_2x_upscale_kernel.sv
// Super Eagle 2x kernel: takes one twelve-pixel neighbourhood per transfer and returns the
// 2x2 output block for its centre pixel. Throughput is one neighbourhood per clock while
// out_ready is high; a result passes the input register, blend logic and result register
// before it is offered, and it stays offered while out_ready holds it back.
// pixel_format (wr_en/wr_data) selects RGB565 in the low 16 bits (0, reset) or XRGB8888
// (1); write it only while no item is in flight. Raster walk and edge replication belong
// to the line buffers outside.
`include "super_eagle_2x_upscale_kernel_assert.svh"

module super_eagle_2x_upscale_kernel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic                wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  se2x_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output se2x_pkg::out_item_t out_pixels
);
	import se2x_pkg::*;

	logic      pixel_format_q;
	logic      v_s1;
	logic      v_s2;
	logic      adv_s2;
	in_item_t  item_s1;
	out_item_t result;
	out_item_t result_s2;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGB565;
		end else if (wr_en) begin
			pixel_format_q <= wr_data;
		end
	end

	// flow control: each stage moves when the one after it is free
	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv_s2 && v_s1) begin
			result_s2 <= result;
		end
	end

	se2x_core u_core (
		.item   (item_s1),
		.fmt    (pixel_format_q),
		.result (result)
	);

	assign out_valid  = v_s2;
	assign out_pixels = result_s2;

	// an input transfer always lands in stage 1
	`SE2X_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, v_s1)
	// a stage-1 item moves on whenever the result slot is free
	`SE2X_ASSERT_NEXT(a_s1_moves_on, clk, arst_n, v_s1 && adv_s2, out_valid)
	// an empty input stage never stalls the source
	`SE2X_ASSERT_SAME(a_empty_s1_ready, clk, arst_n, !v_s1, in_ready)
	// a held result keeps stage 1 from being overwritten while it is full
	`SE2X_ASSERT_SAME(a_full_stall, clk, arst_n, v_s1 && out_valid && !out_ready, !in_ready)

endmodule
